[rtl/xorshift_permutation_generator_unit_defines.svh]
// Assertion macros for the module that carries checks.
`ifndef XORSHIFT_PERMUTATION_GENERATOR_UNIT_DEFINES_SVH
`define XORSHIFT_PERMUTATION_GENERATOR_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define XPG_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("xpg check failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define XPG_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("xpg check failed: next-cycle implication");

`endif

[rtl/xpg_pkg.sv]
package xpg_pkg;

  localparam int MAX_LEN      = 1024;
  localparam int ADDR_W       = $clog2(MAX_LEN);
  localparam int LEN_W        = ADDR_W + 1;
  localparam int RNG_W        = 32;
  localparam int LENGTH_RESET = 1024;

  // Width of the bit counter in the remainder unit, one count per dividend bit.
  localparam int CNT_W        = $clog2(RNG_W);

  typedef enum logic {
    OP_GEN  = 1'b0,
    OP_READ = 1'b1
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [ADDR_W-1:0] index;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] value;
    logic              error;
  } rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_INIT,
    ST_RNG,
    ST_DIV,
    ST_RDJ,
    ST_WRI,
    ST_WRJ,
    ST_DONE
  } st_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic init_wr;
    logic rng_step;
    logic rd_j;
    logic wr_i;
    logic wr_j;
    logic emit;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_done;
    logic short_gen;
    logic last_step;
    logic slot_free;
  } ctl_stat_t;

  // One step of the 13/17/5 xorshift generator.
  function automatic logic [RNG_W-1:0] rng_advance(input logic [RNG_W-1:0] x);
    logic [RNG_W-1:0] y;
    y = x ^ (x << 13);
    y = y ^ (y >> 17);
    y = y ^ (y << 5);
    return y;
  endfunction

endpackage

[rtl/xpg_ram.sv]
module xpg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read data is registered and holds until the next read.
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

[rtl/xpg_divu.sv]
module xpg_divu (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [xpg_pkg::RNG_W-1:0]   dividend,
  input  logic [xpg_pkg::ADDR_W-1:0]  divisor,
  output logic                        done,
  output logic [xpg_pkg::ADDR_W-1:0]  rem
);

  import xpg_pkg::*;

  logic               busy;
  logic [CNT_W-1:0]   cnt;
  logic [RNG_W-1:0]   quo;
  logic [ADDR_W:0]    trial;
  logic [ADDR_W-1:0]  rem_next;

  // Restoring remainder, one dividend bit per cycle, most significant first.
  always_comb begin
    trial = {rem, quo[RNG_W-1]};
    if (trial >= {1'b0, divisor}) begin
      rem_next = ADDR_W'(trial - {1'b0, divisor});
    end else begin
      rem_next = trial[ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(RNG_W - 1);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (busy) begin
      quo <= {quo[RNG_W-2:0], 1'b0};
      rem <= rem_next;
    end
  end

endmodule

[rtl/xpg_ctrl.sv]
module xpg_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  input  xpg_pkg::op_t       cmd_op,
  input  xpg_pkg::ctl_stat_t stat,
  output logic               cmd_stall,
  output xpg_pkg::ctl_cmd_t  ctl
);

  import xpg_pkg::*;

  st_t state;
  st_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          state_next = (cmd_op == OP_READ) ? ST_READ : ST_INIT;
        end
      end
      ST_READ: begin
        if (stat.slot_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_INIT: begin
        state_next = stat.short_gen ? ST_DONE : ST_RNG;
      end
      ST_RNG: begin
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (stat.div_done) begin
          state_next = ST_RDJ;
        end
      end
      ST_RDJ: begin
        state_next = ST_WRI;
      end
      ST_WRI: begin
        state_next = ST_WRJ;
      end
      ST_WRJ: begin
        state_next = stat.last_step ? ST_DONE : ST_RNG;
      end
      ST_DONE: begin
        if (stat.slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_stall    = (state != ST_IDLE);
    ctl          = '0;
    ctl.load     = (state == ST_IDLE) && cmd_valid;
    ctl.init_wr  = (state == ST_INIT);
    ctl.rng_step = (state == ST_RNG);
    ctl.rd_j     = (state == ST_RDJ);
    ctl.wr_i     = (state == ST_WRI);
    ctl.wr_j     = (state == ST_WRJ);
    ctl.emit     = ((state == ST_READ) || (state == ST_DONE)) && stat.slot_free;
  end

endmodule

[rtl/xpg_dp.sv]
module xpg_dp (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  input  logic [xpg_pkg::LEN_W-1:0]  cfg_length,
  input  xpg_pkg::req_t              cmd,
  input  xpg_pkg::ctl_cmd_t          ctl,
  output xpg_pkg::ctl_stat_t         stat,
  input  logic                       rsp_stall,
  output logic                       rsp_valid,
  output xpg_pkg::rsp_t              rsp
);

  import xpg_pkg::*;

  logic [LEN_W-1:0]  length;
  logic [LEN_W-1:0]  n_eff;
  logic [LEN_W-1:0]  perm_length;
  logic              perm_valid;
  logic [RNG_W-1:0]  rng_word;
  logic [RNG_W-1:0]  rng_adv;
  logic [ADDR_W-1:0] pos;
  logic              op_rd;
  logic              rd_err;

  logic              div_done;
  logic [ADDR_W-1:0] j_idx;

  logic              ram_en;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [ADDR_W-1:0] ram_wdata;
  logic [ADDR_W-1:0] ram_rdata;

  assign n_eff   = (length > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : length;
  assign rng_adv = rng_advance(rng_word);

  always_ff @(posedge clk) begin
    if (rst) begin
      length <= LEN_W'(LENGTH_RESET);
    end else if (cfg_valid) begin
      length <= cfg_length;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      perm_length <= '0;
      perm_valid  <= 1'b0;
      rng_word    <= '0;
    end else if (ctl.load && (cmd.op == OP_GEN)) begin
      perm_length <= n_eff;
      perm_valid  <= 1'b1;
      rng_word    <= RNG_W'(n_eff >> 1);
    end else if (ctl.rng_step) begin
      rng_word <= rng_adv;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      op_rd  <= (cmd.op == OP_READ);
      rd_err <= !perm_valid || (LEN_W'(cmd.index) >= perm_length);
      pos    <= ADDR_W'(1);
    end else if (ctl.wr_j) begin
      pos <= pos + ADDR_W'(1);
    end
  end

  xpg_divu u_divu (
    .clk      (clk),
    .rst      (rst),
    .start    (ctl.rng_step),
    .dividend (rng_adv),
    .divisor  (pos),
    .done     (div_done),
    .rem      (j_idx)
  );

  // Entry pos is still untouched when its step comes, so only entry j is read.
  always_comb begin
    ram_en    = (ctl.load && (cmd.op == OP_READ)) || ctl.init_wr || ctl.rd_j ||
                ctl.wr_i || ctl.wr_j;
    ram_we    = ctl.init_wr || ctl.wr_i || ctl.wr_j;
    ram_addr  = '0;
    ram_wdata = '0;
    if (ctl.load) begin
      ram_addr = cmd.index;
    end else if (ctl.rd_j || ctl.wr_j) begin
      ram_addr = j_idx;
    end else if (ctl.wr_i) begin
      ram_addr = pos;
    end
    if (ctl.wr_i) begin
      ram_wdata = ram_rdata;
    end else if (ctl.wr_j) begin
      ram_wdata = pos;
    end
  end

  xpg_ram #(
    .WIDTH (ADDR_W),
    .DEPTH (MAX_LEN)
  ) u_store (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctl.emit) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      rsp.value <= (op_rd && !rd_err) ? ram_rdata : '0;
      rsp.error <= op_rd && rd_err;
    end
  end

  always_comb begin
    stat.div_done  = div_done;
    stat.short_gen = (perm_length <= LEN_W'(1));
    stat.last_step = (LEN_W'(pos) == (perm_length - LEN_W'(1)));
    stat.slot_free = !rsp_valid || !rsp_stall;
  end

endmodule

[rtl/xorshift_permutation_generator_unit.sv]
// Channel   Signals                          Moves
// cmd       cmd_valid / cmd_stall, cmd      op and index into the block
// rsp       rsp_valid / rsp_stall, rsp      value and error out of the block
// cfg       cfg_valid / cfg_ready, cfg_length   length register write
//
// A read moves from the store's read register to the output register once that is free.
// Each shuffle position costs one generator step, a full run of the bit-serial
// remainder unit and three store accesses on the single store port.
// Reset is synchronous; the store is not cleared, and reads before a shuffle report error.
// A finished result waits in the output register while the next command is taken.
`include "xorshift_permutation_generator_unit_defines.svh"

module xorshift_permutation_generator_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cmd_valid,
  output logic                       cmd_stall,
  input  xpg_pkg::req_t              cmd,
  output logic                       rsp_valid,
  input  logic                       rsp_stall,
  output xpg_pkg::rsp_t              rsp,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [xpg_pkg::LEN_W-1:0]  cfg_length
);

  import xpg_pkg::*;

  ctl_cmd_t  ctl;
  ctl_stat_t stat;

  // The length register takes a transfer in any cycle; a shuffle samples it
  // only when its command is taken, so later writes affect the next shuffle.
  assign cfg_ready = 1'b1;

  // The controller sequences each command; it accepts a new one only when idle.
  xpg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_op    (cmd.op),
    .stat      (stat),
    .cmd_stall (cmd_stall),
    .ctl       (ctl)
  );

  // The datapath holds the generator, the remainder unit, the permutation store
  // and the output register.
  xpg_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_length (cfg_length),
    .cmd        (cmd),
    .ctl        (ctl),
    .stat       (stat),
    .rsp_stall  (rsp_stall),
    .rsp_valid  (rsp_valid),
    .rsp        (rsp)
  );

  // A taken command always keeps the block busy for at least the next cycle.
  `XPG_ASSERT_NXT(a_busy_after_accept, clk, rst, cmd_valid && !cmd_stall, cmd_stall)
  // An error result never carries a value.
  `XPG_ASSERT_IMP(a_error_zero_value, clk, rst, rsp_valid && rsp.error, rsp.value == '0)
  // Reset leaves no result pending.
  `XPG_ASSERT_NXT(a_reset_clears_rsp, clk, 1'b0, rst, !rsp_valid)

endmodule

[tb/tb_top.sv]
module tb_top;

  import xpg_pkg::*;

  // Clock, reset and the three channels of the block.
  logic               clk = 1'b0;
  logic               rst;
  logic               cmd_valid;
  logic               cmd_stall;
  req_t               cmd;
  logic               rsp_valid;
  logic               rsp_stall;
  rsp_t               rsp;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [LEN_W-1:0]   cfg_length;

  // Our own copy of the block's state, kept in step with every accepted transfer.
  logic [ADDR_W-1:0]  perm_copy [MAX_LEN];
  logic [RNG_W-1:0]   rng_copy;
  logic               perm_ready_copy;
  logic [LEN_W-1:0]   perm_len_copy;
  logic [LEN_W-1:0]   length_copy;

  // Answers that the block still owes us, oldest first.
  rsp_t               answers_due [$];

  // Knobs set by the test sequence for its own command feed and the response process.
  bit                 feed_random;
  bit                 sink_random;
  int unsigned        hold_cycles;

  // Tallies for the closing summary.
  int unsigned        mismatches;
  int unsigned        shuffles_sent;
  int unsigned        good_reads;
  int unsigned        bad_reads;
  int unsigned        holds_done;
  int unsigned        lengths_written;
  logic [LEN_W-1:0]   longest_written;

  xorshift_permutation_generator_unit DUT (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_stall  (cmd_stall),
    .cmd        (cmd),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp        (rsp),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_length (cfg_length)
  );

  always #4 clk = ~clk;

  // Idle stretch lengths mostly come from the lower of two ranges, with the occasional long one so that
  // gaps land on every stage of a shuffle as well as on reads.
  function automatic int unsigned gap_length();
    if ($urandom_range(0, 7) != 0) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 60);
  endfunction

  // One step of the 13/17/5 xorshift sequence, modulo 2^32.
  function automatic logic [RNG_W-1:0] xs_step(input logic [RNG_W-1:0] s);
    logic [RNG_W-1:0] t;
    t = s ^ (s << 13);
    t = t ^ (t >> 17);
    t = t ^ (t << 5);
    return t;
  endfunction

  // The shuffle: identity fill, seed with half the length, then one swap per
  // position against an earlier slot. The length saturates at the store depth.
  function automatic void shuffle_copy();
    int unsigned n;
    int unsigned k;
    int unsigned j;
    logic [ADDR_W-1:0] t;
    n = (length_copy > MAX_LEN) ? MAX_LEN : length_copy;
    for (k = 0; k < n; k++) begin
      perm_copy[k] = ADDR_W'(k);
    end
    rng_copy = RNG_W'(n / 2);
    for (k = 1; k < n; k++) begin
      rng_copy = xs_step(rng_copy);
      j = rng_copy % k;
      t = perm_copy[k];
      perm_copy[k] = perm_copy[j];
      perm_copy[j] = t;
    end
    perm_len_copy = LEN_W'(n);
    perm_ready_copy = 1'b1;
  endfunction

  // Works out the answer to one accepted command and updates our copy of the state.
  // A shuffle answers with zeros; a read answers with the entry, or with an error
  // when no shuffle has run or the index lies at or past the shuffled length.
  function automatic rsp_t predict_answer(input req_t c);
    rsp_t a;
    a = '0;
    if (c.op == OP_GEN) begin
      shuffle_copy();
    end else if (!perm_ready_copy || c.index >= perm_len_copy) begin
      a.error = 1'b1;
    end else begin
      a.value = perm_copy[c.index];
    end
    return a;
  endfunction

  // Offers one command and waits for its transfer. Valid is left high afterwards so
  // that back-to-back commands need no second assignment in the same time step; it
  // is only lowered for a gap or by finish_phase.
  task automatic send_cmd(input op_t op, input logic [ADDR_W-1:0] idx);
    req_t c;
    rsp_t a;
    int unsigned gap;
    gap = (feed_random && $urandom_range(0, 3) == 0) ? gap_length() : 0;
    if (gap != 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    c.op = op;
    c.index = idx;
    cmd_valid <= 1'b1;
    cmd <= c;
    @(posedge clk);
    while (cmd_stall !== 1'b0) @(posedge clk);
    a = predict_answer(c);
    answers_due.push_back(a);
    if (op == OP_GEN) begin
      shuffles_sent++;
    end else if (a.error) begin
      bad_reads++;
    end else begin
      good_reads++;
    end
  endtask

  // Stops offering commands and waits until every owed answer has come back, which
  // leaves the block idle since each command yields exactly one answer.
  task automatic finish_phase();
    cmd_valid <= 1'b0;
    do @(posedge clk); while (answers_due.size() != 0);
  endtask

  // Writes the length register; only ever called with the block idle.
  task automatic write_length(input logic [LEN_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_length <= v;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    cfg_valid <= 1'b0;
    length_copy = v;
    lengths_written++;
    if (v > longest_written) begin
      longest_written = v;
    end
  endtask

  // Reads before any shuffle must all come back as errors.
  task automatic test_read_before_generate();
    send_cmd(OP_READ, '0);
    send_cmd(OP_READ, '1);
    finish_phase();
  endtask

  // A length of one leaves the identity in place: slot 0 holds 0, slot 1 is an error.
  task automatic test_single_element();
    write_length(LEN_W'(1));
    send_cmd(OP_GEN, '0);
    send_cmd(OP_READ, '0);
    send_cmd(OP_READ, ADDR_W'(1));
    finish_phase();
  endtask

  // A length of zero still counts as a shuffle, but leaves nothing readable.
  task automatic test_zero_length();
    write_length('0);
    send_cmd(OP_GEN, '1);
    send_cmd(OP_READ, '0);
    finish_phase();
  endtask

  // The largest register value saturates at the store depth, so the far end of the
  // store becomes readable; alternating index patterns toggle every index bit.
  task automatic test_saturated_length();
    write_length('1);
    send_cmd(OP_GEN, '0);
    send_cmd(OP_READ, '0);
    send_cmd(OP_READ, '1);
    send_cmd(OP_READ, ADDR_W'(10'b0101010101));
    send_cmd(OP_READ, ADDR_W'(10'b1010101010));
    send_cmd(OP_READ, ADDR_W'(MAX_LEN / 2));
    finish_phase();
  endtask

  // The response side holds off for a long stretch while commands keep
  // coming, so the block fills up and has to stall its command channel.
  task automatic test_back_pressure();
    feed_random = 1'b0;
    sink_random = 1'b0;
    hold_cycles = 300;
    repeat (24) send_cmd(OP_READ, ADDR_W'($urandom_range(0, MAX_LEN - 1)));
    finish_phase();
  endtask

  // Changing the length without a new shuffle must not move the readable range.
  task automatic test_stale_length();
    feed_random = 1'b1;
    sink_random = 1'b1;
    write_length(LEN_W'(3));
    send_cmd(OP_GEN, '0);
    finish_phase();
    write_length(LEN_W'(9));
    send_cmd(OP_READ, ADDR_W'(2));
    send_cmd(OP_READ, ADDR_W'(3));
    send_cmd(OP_READ, ADDR_W'(8));
    send_cmd(OP_GEN, '0);
    send_cmd(OP_READ, ADDR_W'(8));
    finish_phase();
  endtask

  // Random phases: each picks a length (mostly short, a few medium, at most two at or
  // above the store depth), usually shuffles, then reads mostly inside the shuffled
  // range, with stray out-of-range reads and the odd extra shuffle mixed in.
  task automatic test_random_phases();
    int unsigned sent;
    int unsigned burst;
    int unsigned pick;
    int unsigned big_left;
    logic [LEN_W-1:0] len;
    sent = 0;
    big_left = 2;
    while (sent < 1100) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        len = '0;
      end else if (pick < 80) begin
        len = LEN_W'($urandom_range(1, 40));
      end else if (pick < 96 || big_left == 0) begin
        len = LEN_W'($urandom_range(41, 300));
      end else begin
        big_left--;
        len = ($urandom_range(0, 1) != 0) ? LEN_W'(MAX_LEN) : LEN_W'($urandom_range(1025, 2047));
      end
      // Some phases run with no idling at all on one side or both.
      feed_random = ($urandom_range(0, 3) != 0);
      sink_random = ($urandom_range(0, 3) != 0);
      write_length(len);
      if ($urandom_range(0, 9) != 0) begin
        send_cmd(OP_GEN, ADDR_W'($urandom_range(0, MAX_LEN - 1)));
        sent++;
      end
      burst = $urandom_range(10, 50);
      repeat (burst) begin
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
          send_cmd(OP_GEN, ADDR_W'($urandom_range(0, MAX_LEN - 1)));
        end else if (pick < 80 && perm_ready_copy && perm_len_copy != 0) begin
          send_cmd(OP_READ, ADDR_W'($urandom_range(0, perm_len_copy - 1)));
        end else begin
          send_cmd(OP_READ, ADDR_W'($urandom_range(0, MAX_LEN - 1)));
        end
        sent++;
      end
      finish_phase();
    end
  endtask

  // Response side: random stalls when asked, and a long hold-off counted here in
  // cycles whenever the test sequence requests one.
  initial begin : response_sink
    int unsigned n;
    rsp_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles != 0) begin
        n = hold_cycles;
        hold_cycles = 0;
        rsp_stall <= 1'b1;
        repeat (n) @(posedge clk);
        rsp_stall <= 1'b0;
        holds_done++;
      end else if (sink_random && $urandom_range(0, 3) == 0) begin
        rsp_stall <= 1'b1;
        repeat (gap_length()) @(posedge clk);
        rsp_stall <= 1'b0;
      end
    end
  end

  // Every answer transfer is compared, field by field, with the oldest owed answer.
  always @(posedge clk) begin
    rsp_t want;
    if (rst !== 1'b1 && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
      if (answers_due.size() == 0) begin
        mismatches++;
        $display("%0t: answer with none owed: value %0d error %0b", $time, rsp.value,
                 rsp.error);
      end else begin
        want = answers_due.pop_front();
        if (rsp.value !== want.value) begin
          mismatches++;
          $display("%0t: value expected %0d, got %0d", $time, want.value, rsp.value);
        end
        if (rsp.error !== want.error) begin
          mismatches++;
          $display("%0t: error expected %0b, got %0b", $time, want.error, rsp.error);
        end
      end
    end
  end

  initial begin
    rst <= 1'b1;
    cmd_valid <= 1'b0;
    cmd <= '0;
    cfg_valid <= 1'b0;
    cfg_length <= '0;
    perm_ready_copy = 1'b0;
    perm_len_copy = '0;
    rng_copy = '0;
    length_copy = LEN_W'(LENGTH_RESET);
    feed_random = 1'b1;
    sink_random = 1'b1;
    hold_cycles = 0;
    longest_written = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_read_before_generate();
    test_single_element();
    test_zero_length();
    test_saturated_length();
    test_back_pressure();
    test_stale_length();
    test_random_phases();

    // A short settle lets any stray answers arrive before the summary.
    repeat (20) @(posedge clk);
    $display("Run covered %0d shuffles, %0d good reads and %0d error reads,",
             shuffles_sent, good_reads, bad_reads);
    $display("%0d length writes up to %0d, and %0d long response hold-offs.",
             lengths_written, longest_written, holds_done);
    if (mismatches == 0 && answers_due.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Guard against a hang: far beyond the slowest correct run, large shuffles included.
  initial begin
    #40_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
